### sv/convex_hull_graham_scan_core_assert.svh
// Assertion macros for the hull core.
`ifndef CONVEX_HULL_GRAHAM_SCAN_CORE_ASSERT_SVH
`define CONVEX_HULL_GRAHAM_SCAN_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CHGS_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hull core assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CHGS_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hull core assertion failed");

`endif

### sv/chgs_pkg.sv
// ----------------------------------------------------------------------------
// chgs_pkg: shared types and defaults of the hull core
// Sequencer state encoding, multiplier control group and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package chgs_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PV_RD,
        ST_PV_CMP,
        ST_SW_RD,
        ST_SW_WR0,
        ST_SW_WRL,
        ST_SO_RDJ,
        ST_SO_RDK,
        ST_SO_VEC,
        ST_SO_MUL,
        ST_SO_CHK,
        ST_SO_DB,
        ST_SO_DC,
        ST_SO_WRJ,
        ST_SO_WRK,
        ST_SC_INIT,
        ST_SC_ONE,
        ST_SC_RDI,
        ST_SC_LDI,
        ST_SC_TST,
        ST_SC_RDP,
        ST_SC_VEC,
        ST_SC_MUL,
        ST_SC_DEC,
        ST_EM_RDS,
        ST_EM_RDP,
        ST_EM_OUT,
        ST_EM_WAIT
    } state_t;

    typedef struct packed {
        logic load;   // capture a new product pair
        logic sum;    // combine as p + q instead of p - q
    } mul_ctrl_t;

endpackage

### sv/chgs_ram.sv
// ----------------------------------------------------------------------------
// chgs_ram: single-port-write, single-port-read synchronous memory
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

### sv/chgs_mul.sv
// ----------------------------------------------------------------------------
// chgs_mul: product-pair unit
// Registers two signed products and presents their sum or difference,
// serving both the cross product and the squared distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chgs_mul #(
    parameter int DW = 17
) (
    input  logic                    aclk,
    input  chgs_pkg::mul_ctrl_t     ctrl,
    input  logic signed [DW-1:0]    a0,
    input  logic signed [DW-1:0]    b0,
    input  logic signed [DW-1:0]    a1,
    input  logic signed [DW-1:0]    b1,
    output logic signed [2*DW:0]    res
);
    import chgs_pkg::*;

    logic signed [2*DW-1:0] p_reg;
    logic signed [2*DW-1:0] q_reg;
    logic                   sum_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            p_reg   <= a0 * b0;
            q_reg   <= a1 * b1;
            sum_reg <= ctrl.sum;
        end
    end

    always_comb begin
        if (sum_reg) begin
            res = (2*DW+1)'(p_reg) + (2*DW+1)'(q_reg);
        end else begin
            res = (2*DW+1)'(p_reg) - (2*DW+1)'(q_reg);
        end
    end

endmodule

### sv/convex_hull_graham_scan_core.sv
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_core: Graham-scan convex hull engine
// Loads a point set, finds the pivot, insertion-sorts by angle, runs the
// stack scan and streams the hull from the stack top down to the pivot.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_px, s_py, s_final_point
//   m_       out  m_valid/m_ready    m_hx, m_hy, m_end_of_hull, m_points_dropped
//
// Loading takes a request whenever s_valid is high. After the final request
// the core runs the pivot search point by point, the swap, the sort compares
// (a collinear tie adds a squared-distance compare, a swap two writes), the
// scan seed, each scan point with its turn tests (a direct push when only
// the pivot remains) and the hull vertices, each held by output stall.
// Reset (synchronous, active low) clears control only; memories hold no
// reset value. s_ready is low from the final request until the last vertex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "convex_hull_graham_scan_core_assert.svh"
module convex_hull_graham_scan_core #(
    parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgs_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_px,
    input  logic signed [COORD_BITS-1:0] s_py,
    input  logic                         s_final_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_hx,
    output logic signed [COORD_BITS-1:0] m_hy,
    output logic                         m_end_of_hull,
    output logic                         m_points_dropped
);
    import chgs_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int C     = COORD_BITS;
    localparam int D     = COORD_BITS + 1;
    localparam int R     = 2 * D + 1;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic              m_valid_reg, m_valid_next;

    // Datapath registers
    logic [IDX_W-1:0]     low_reg, low_next;
    logic signed [C-1:0]  lowx_reg, lowx_next, lowy_reg, lowy_next;
    logic signed [C-1:0]  pivx_reg, pivx_next, pivy_reg, pivy_next;
    logic signed [C-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic signed [C-1:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic signed [C-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [D-1:0]  ux_reg, ux_next, uy_reg, uy_next;
    logic signed [D-1:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic signed [R-1:0]  da_reg, da_next;
    logic signed [C-1:0]  hx_reg, hx_next, hy_reg, hy_next;
    logic                 eoh_reg, eoh_next, drop_reg, drop_next;

    // Memory ports
    logic                 pt_we;
    logic [IDX_W-1:0]     pt_wa, pt_ra;
    logic [2*C-1:0]       pt_wd, pt_rd;
    logic                 sm_we;
    logic [IDX_W-1:0]     sm_wa, sm_ra;
    logic [IDX_W-1:0]     sm_wd, sm_rd;

    // Product unit
    mul_ctrl_t            mctl;
    logic signed [D-1:0]  m_a0, m_b0, m_a1, m_b1;
    logic signed [R-1:0]  m_res;

    logic signed [C-1:0]  rd_x, rd_y;
    logic [CNT_W-1:0]     i_inc;
    logic                 res_pos, res_zero;

    assign rd_x     = pt_rd[2*C-1:C];
    assign rd_y     = pt_rd[C-1:0];
    assign i_inc    = i_reg + CNT_W'(1);
    assign res_zero = (m_res == '0);
    assign res_pos  = !m_res[R-1] && !res_zero;

    chgs_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_pt_mem (
        .aclk (aclk),
        .we   (pt_we),
        .wa   (pt_wa),
        .wd   (pt_wd),
        .ra   (pt_ra),
        .rd   (pt_rd)
    );

    chgs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_stk_mem (
        .aclk (aclk),
        .we   (sm_we),
        .wa   (sm_wa),
        .wd   (sm_wd),
        .ra   (sm_ra),
        .rd   (sm_rd)
    );

    chgs_mul #(.DW(D)) u_mul (
        .aclk (aclk),
        .ctrl (mctl),
        .a0   (m_a0),
        .b0   (m_b0),
        .a1   (m_a1),
        .b1   (m_b1),
        .res  (m_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg  <= low_next;
        lowx_reg <= lowx_next;
        lowy_reg <= lowy_next;
        pivx_reg <= pivx_next;
        pivy_reg <= pivy_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        da_reg   <= da_next;
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
        eoh_reg  <= eoh_next;
        drop_reg <= drop_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        depth_next   = depth_reg;
        m_valid_next = m_valid_reg;
        low_next     = low_reg;
        lowx_next    = lowx_reg;
        lowy_next    = lowy_reg;
        pivx_next    = pivx_reg;
        pivy_next    = pivy_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        ux_next      = ux_reg;
        uy_next      = uy_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        da_next      = da_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        eoh_next     = eoh_reg;
        drop_next    = drop_reg;

        pt_we = 1'b0;
        pt_wa = '0;
        pt_wd = {s_px, s_py};
        pt_ra = i_reg[IDX_W-1:0];
        sm_we = 1'b0;
        sm_wa = depth_reg[IDX_W-1:0];
        sm_wd = i_reg[IDX_W-1:0];
        sm_ra = '0;
        mctl  = '{load: 1'b0, sum: 1'b0};
        m_a0  = ux_reg;
        m_b0  = vy_reg;
        m_a1  = uy_reg;
        m_b1  = vx_reg;
        s_ready = 1'b0;

        unique case (state_reg)
            // Take points; store while room remains, else flag the drop.
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                        pt_we    = 1'b1;
                        pt_wa    = cnt_reg[IDX_W-1:0];
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_final_point) begin
                        i_next     = '0;
                        state_next = ST_PV_RD;
                    end
                end
            end
            // Pivot search: lowest y, then lowest x, first one wins.
            ST_PV_RD: begin
                pt_ra      = i_reg[IDX_W-1:0];
                state_next = ST_PV_CMP;
            end
            ST_PV_CMP: begin
                if (i_reg == '0 || rd_y < lowy_reg ||
                    (rd_y == lowy_reg && rd_x < lowx_reg)) begin
                    low_next  = i_reg[IDX_W-1:0];
                    lowx_next = rd_x;
                    lowy_next = rd_y;
                end
                i_next = i_inc;
                if (i_inc < cnt_reg) begin
                    state_next = ST_PV_RD;
                end else begin
                    state_next = ST_SW_RD;
                end
            end
            // Swap the pivot into entry zero.
            ST_SW_RD: begin
                pt_ra      = '0;
                pivx_next  = lowx_reg;
                pivy_next  = lowy_reg;
                state_next = ST_SW_WR0;
            end
            ST_SW_WR0: begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                pt_we      = 1'b1;
                pt_wa      = '0;
                pt_wd      = {lowx_reg, lowy_reg};
                state_next = ST_SW_WRL;
            end
            ST_SW_WRL: begin
                pt_we  = 1'b1;
                pt_wa  = low_reg;
                pt_wd  = {ax_reg, ay_reg};
                i_next = CNT_W'(2);
                j_next = CNT_W'(2);
                if (cnt_reg > CNT_W'(2)) begin
                    state_next = ST_SO_RDJ;
                end else begin
                    state_next = ST_SC_INIT;
                end
            end
            // Insertion sort: compare entry j against entry j-1.
            ST_SO_RDJ: begin
                pt_ra      = j_reg[IDX_W-1:0];
                state_next = ST_SO_RDK;
            end
            ST_SO_RDK: begin
                pt_ra      = IDX_W'(j_reg - CNT_W'(1));
                ax_next    = rd_x;
                ay_next    = rd_y;
                state_next = ST_SO_VEC;
            end
            ST_SO_VEC: begin
                tx_next    = rd_x;
                ty_next    = rd_y;
                ux_next    = D'(ax_reg) - D'(pivx_reg);
                uy_next    = D'(ay_reg) - D'(pivy_reg);
                vx_next    = D'(rd_x) - D'(pivx_reg);
                vy_next    = D'(rd_y) - D'(pivy_reg);
                state_next = ST_SO_MUL;
            end
            ST_SO_MUL: begin
                mctl       = '{load: 1'b1, sum: 1'b0};
                state_next = ST_SO_CHK;
            end
            ST_SO_CHK: begin
                if (res_pos) begin
                    state_next = ST_SO_WRJ;
                end else if (!res_zero) begin
                    state_next = ST_SO_DB;
                    i_next     = i_inc;
                    j_next     = i_inc;
                    if (i_inc >= cnt_reg) begin
                        state_next = ST_SC_INIT;
                    end else begin
                        state_next = ST_SO_RDJ;
                    end
                end else begin
                    // Collinear: fall back to squared distance.
                    mctl       = '{load: 1'b1, sum: 1'b1};
                    m_a0       = ux_reg;
                    m_b0       = ux_reg;
                    m_a1       = uy_reg;
                    m_b1       = uy_reg;
                    state_next = ST_SO_DB;
                end
            end
            ST_SO_DB: begin
                da_next    = m_res;
                mctl       = '{load: 1'b1, sum: 1'b1};
                m_a0       = vx_reg;
                m_b0       = vx_reg;
                m_a1       = vy_reg;
                m_b1       = vy_reg;
                state_next = ST_SO_DC;
            end
            ST_SO_DC: begin
                if (da_reg < m_res) begin
                    state_next = ST_SO_WRJ;
                end else begin
                    i_next = i_inc;
                    j_next = i_inc;
                    if (i_inc >= cnt_reg) begin
                        state_next = ST_SC_INIT;
                    end else begin
                        state_next = ST_SO_RDJ;
                    end
                end
            end
            ST_SO_WRJ: begin
                pt_we      = 1'b1;
                pt_wa      = j_reg[IDX_W-1:0];
                pt_wd      = {tx_reg, ty_reg};
                state_next = ST_SO_WRK;
            end
            ST_SO_WRK: begin
                pt_we  = 1'b1;
                pt_wa  = IDX_W'(j_reg - CNT_W'(1));
                pt_wd  = {ax_reg, ay_reg};
                if (j_reg > CNT_W'(2)) begin
                    j_next     = j_reg - CNT_W'(1);
                    state_next = ST_SO_RDJ;
                end else begin
                    i_next = i_inc;
                    j_next = i_inc;
                    if (i_inc >= cnt_reg) begin
                        state_next = ST_SC_INIT;
                    end else begin
                        state_next = ST_SO_RDJ;
                    end
                end
            end
            // Scan: seed the stack with the pivot and the first sorted point.
            ST_SC_INIT: begin
                sm_we      = 1'b1;
                sm_wa      = '0;
                sm_wd      = '0;
                depth_next = CNT_W'(1);
                tx_next    = pivx_reg;
                ty_next    = pivy_reg;
                pt_ra      = IDX_W'(1);
                state_next = ST_SC_ONE;
            end
            ST_SC_ONE: begin
                if (cnt_reg > CNT_W'(1)) begin
                    sm_we      = 1'b1;
                    sm_wa      = IDX_W'(1);
                    sm_wd      = IDX_W'(1);
                    depth_next = CNT_W'(2);
                    tx_next    = rd_x;
                    ty_next    = rd_y;
                end
                i_next = CNT_W'(2);
                if (cnt_reg > CNT_W'(2)) begin
                    state_next = ST_SC_RDI;
                end else begin
                    state_next = ST_EM_RDS;
                end
            end
            ST_SC_RDI: begin
                pt_ra      = i_reg[IDX_W-1:0];
                state_next = ST_SC_LDI;
            end
            ST_SC_LDI: begin
                cx_next    = rd_x;
                cy_next    = rd_y;
                state_next = ST_SC_TST;
            end
            // Test the turn below-top-current, or push when only one entry.
            ST_SC_TST: begin
                if (depth_reg >= CNT_W'(2)) begin
                    sm_ra      = IDX_W'(depth_reg - CNT_W'(2));
                    state_next = ST_SC_RDP;
                end else begin
                    sm_we      = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    tx_next    = cx_reg;
                    ty_next    = cy_reg;
                    i_next     = i_inc;
                    if (i_inc < cnt_reg) begin
                        state_next = ST_SC_RDI;
                    end else begin
                        state_next = ST_EM_RDS;
                    end
                end
            end
            ST_SC_RDP: begin
                pt_ra      = sm_rd;
                state_next = ST_SC_VEC;
            end
            ST_SC_VEC: begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                ux_next    = D'(tx_reg) - D'(rd_x);
                uy_next    = D'(ty_reg) - D'(rd_y);
                vx_next    = D'(cx_reg) - D'(rd_x);
                vy_next    = D'(cy_reg) - D'(rd_y);
                state_next = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                mctl       = '{load: 1'b1, sum: 1'b0};
                state_next = ST_SC_DEC;
            end
            ST_SC_DEC: begin
                if (res_pos) begin
                    // Strict left turn: push the current point.
                    sm_we      = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    tx_next    = cx_reg;
                    ty_next    = cy_reg;
                    i_next     = i_inc;
                    if (i_inc < cnt_reg) begin
                        state_next = ST_SC_RDI;
                    end else begin
                        state_next = ST_EM_RDS;
                    end
                end else begin
                    // Drop the top; the entry below becomes the top.
                    depth_next = depth_reg - CNT_W'(1);
                    tx_next    = ax_reg;
                    ty_next    = ay_reg;
                    state_next = ST_SC_TST;
                end
            end
            // Emit from the stack top down to the pivot.
            ST_EM_RDS: begin
                sm_ra      = IDX_W'(depth_reg - CNT_W'(1));
                state_next = ST_EM_RDP;
            end
            ST_EM_RDP: begin
                pt_ra      = sm_rd;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                hx_next      = rd_x;
                hy_next      = rd_y;
                eoh_next     = (depth_reg == CNT_W'(1));
                drop_next    = ovf_reg;
                m_valid_next = 1'b1;
                state_next   = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    depth_next   = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1)) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_EM_RDS;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_hx             = hx_reg;
    assign m_hy             = hy_reg;
    assign m_end_of_hull    = eoh_reg;
    assign m_points_dropped = drop_reg;

    // Loading and emitting never overlap.
    `CHGS_AST_IMP(a_phase_excl, aclk, aresetn, s_ready, !m_valid)
    // Fill count never passes capacity.
    `CHGS_AST_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_POINTS))
    // The pivot is never popped: a turn test always sees a non-empty stack.
    `CHGS_AST_IMP(a_scan_depth, aclk, aresetn, state_reg == ST_SC_TST, depth_reg != '0)
    // Taking the last vertex returns the core to an empty load phase.
    `CHGS_AST_NXT(a_done_clear, aclk, aresetn, m_valid && m_ready && m_end_of_hull,
        s_ready && cnt_reg == '0 && !ovf_reg)

endmodule
